// ===== hw/rtl/brl_pkg.sv =====
// brl_pkg: item types, command/status structs and coordinate helpers for the
// line rasterizer. Used by brl_ctrl, brl_datapath and bresenham_line_rasterizer.
// No dependencies.
package brl_pkg;

    // tile geometry; coordinates are fixed at 6 bits
    localparam int TILE_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int COLOR_W   = 24;
    localparam int FRAME_W   = 7;
    localparam int ERR_W     = 10;

    // largest coordinate kept after clamping to the tile
    localparam logic [COORD_W-1:0] COORD_MAX =
        (TILE_SIZE >= (1 << COORD_W)) ? {COORD_W{1'b1}} : COORD_W'(TILE_SIZE - 1);

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(64);

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord             start_x;
        t_coord             start_y;
        t_coord             end_x;
        t_coord             end_y;
        logic [COLOR_W-1:0] line_color;
    } t_line_item;

    typedef struct packed {
        t_coord             pixel_x;
        t_coord             pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               inside_frame;
        logic               last_pixel;
    } t_pixel_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_brl_cmd;

    // datapath to controller
    typedef struct packed {
        logic at_end;
    } t_brl_status;

    // saturate a coordinate to the tile
    function automatic t_coord clamp_coord(input t_coord c);
        t_coord res;
        res = (c > COORD_MAX) ? COORD_MAX : c;
        return res;
    endfunction

endpackage

// ===== hw/rtl/brl_ctrl.sv =====
// brl_ctrl: sequencer for the line walk, one pixel per cycle while running.
// Depends on brl_pkg for the command and status structs.
module brl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  brl_pkg::t_brl_status i_status,
    output brl_pkg::t_brl_cmd    o_cmd,
    output logic                 busy
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_busy;

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_RUN;
                        r_busy  <= 1'b1;
                    end
                end
                S_RUN: begin
                    if (i_status.at_end) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // load on an accepted item, emit and advance every running cycle
    always_comb begin
        o_cmd.load = start && !r_busy;
        o_cmd.step = (r_state == S_RUN);
    end

    assign busy = r_busy;

endmodule

// ===== hw/rtl/brl_datapath.sv =====
// brl_datapath: frame registers, Bresenham position/error registers and the
// registered pixel output. Depends on brl_pkg.
module brl_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [brl_pkg::FRAME_W-1:0]       i_cfg_data,
    input  brl_pkg::t_line_item               i_item,
    input  brl_pkg::t_brl_cmd                 i_cmd,
    output brl_pkg::t_brl_status              o_status,
    output logic                              o_valid,
    output brl_pkg::t_pixel_item              o_pixel
);

    localparam int CW = brl_pkg::COORD_W;
    localparam int EW = brl_pkg::ERR_W;

    logic [brl_pkg::FRAME_W-1:0] r_frame_w;
    logic [brl_pkg::FRAME_W-1:0] r_frame_h;

    brl_pkg::t_coord               r_x, r_y, r_xe, r_ye;
    logic signed [CW+1:0]          r_dx;
    logic signed [CW+1:0]          r_dy;
    logic                          r_sx, r_sy;
    logic signed [EW-1:0]          r_err;
    logic [brl_pkg::COLOR_W-1:0]   r_color;

    logic                          r_valid;
    brl_pkg::t_pixel_item          r_pixel;

    brl_pkg::t_coord               ld_x, ld_y, ld_xe, ld_ye;
    logic [CW-1:0]                 ld_adx, ld_ady;
    logic signed [EW:0]            e2;
    logic                          x_move, y_move;
    logic signed [EW-1:0]          n_err;
    logic                          at_end;
    logic                          in_frame;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= brl_pkg::FRAME_RESET;
            r_frame_h <= brl_pkg::FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                brl_pkg::REG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                brl_pkg::REG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // setup values for a new segment
    always_comb begin
        ld_x   = brl_pkg::clamp_coord(i_item.start_x);
        ld_y   = brl_pkg::clamp_coord(i_item.start_y);
        ld_xe  = brl_pkg::clamp_coord(i_item.end_x);
        ld_ye  = brl_pkg::clamp_coord(i_item.end_y);
        ld_adx = (ld_x < ld_xe) ? (ld_xe - ld_x) : (ld_x - ld_xe);
        ld_ady = (ld_y < ld_ye) ? (ld_ye - ld_y) : (ld_y - ld_ye);
    end

    // error term update for one step
    always_comb begin
        e2       = {r_err, 1'b0};
        x_move   = (e2 >= (EW+1)'(r_dy));
        y_move   = (e2 <= (EW+1)'(r_dx));
        n_err    = r_err + (x_move ? EW'(r_dy) : '0) + (y_move ? EW'(r_dx) : '0);
        at_end   = (r_x == r_xe) && (r_y == r_ye);
        in_frame = ({1'b0, r_x} < r_frame_w) && ({1'b0, r_y} < r_frame_h);
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= ld_x;
            r_y     <= ld_y;
            r_xe    <= ld_xe;
            r_ye    <= ld_ye;
            r_dx    <= (CW+2)'(ld_adx);
            r_dy    <= -(CW+2)'(ld_ady);
            r_sx    <= ld_x < ld_xe;
            r_sy    <= ld_y < ld_ye;
            r_err   <= EW'(ld_adx) - EW'(ld_ady);
            r_color <= i_item.line_color;
        end else if (i_cmd.step) begin
            r_err <= n_err;
            if (x_move) begin
                r_x <= r_sx ? r_x + 1'b1 : r_x - 1'b1;
            end
            if (y_move) begin
                r_y <= r_sy ? r_y + 1'b1 : r_y - 1'b1;
            end
        end
    end

    // output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step;
        end
    end

    // output pixel register
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pixel.pixel_x      <= r_x;
            r_pixel.pixel_y      <= r_y;
            r_pixel.pixel_color  <= r_color;
            r_pixel.inside_frame <= in_frame;
            r_pixel.last_pixel   <= at_end;
        end
    end

    assign o_status.at_end = at_end;
    assign o_valid         = r_valid;
    assign o_pixel         = r_pixel;

endmodule

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
// bresenham_line_rasterizer: top level joining the sequencer and the datapath.
// Depends on brl_pkg, brl_ctrl and brl_datapath.
//
// Usage:
//   Present a segment on i_item and raise start; the item is taken at a clock
//   edge where start is high and busy is low. busy then stays high while the
//   segment is walked from start point to end point.
//   While a segment is walked, pixels appear on o_pixel one per cycle, each marked by o_valid for exactly
//   one cycle; the receiver must take them as they come. The final pixel of a
//   segment carries last_pixel.
//   The accepted item is loaded into the walk registers; each walk step then
//   registers the current point into o_pixel and advances the walk.
//   A segment of N pixels (N = max(|dx|,|dy|) + 1, 1 to 64) keeps the block
//   busy until its end point is stepped, one error-term step per pixel; the next
//   item can be accepted in the cycle that shows the last pixel, so a new item
//   is not taken while the previous segment is still being walked.
//   Frame width and height are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while idle; each resets to 64.
//   Reset (i_rst_n low, synchronous) returns to idle and drops o_valid.
module bresenham_line_rasterizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  brl_pkg::t_line_item             i_item,
    output logic                            o_valid,
    output brl_pkg::t_pixel_item            o_pixel,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [brl_pkg::FRAME_W-1:0]     i_cfg_data
);

    brl_pkg::t_brl_cmd    cmd;
    brl_pkg::t_brl_status status;

    // walk sequencer
    brl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // position, error and output registers
    brl_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_pixel     (o_pixel)
    );

endmodule

// ===== sim/bresenham_line_rasterizer_tb.sv =====
// bresenham_line_rasterizer_tb: self-checking bench for the line rasterizer, with a
// line-walk predictor, a queued start/busy driver and a pixel monitor.
// Depends on brl_pkg and bresenham_line_rasterizer.
module bresenham_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_LINES  = 41;
    localparam int MAX_PRINTED  = 30;

    typedef struct {
        brl_pkg::t_line_item line;
        bit                  wait_drain;
    } t_pending_line;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    brl_pkg::t_line_item          i_item = '0;
    logic                         o_valid;
    brl_pkg::t_pixel_item         o_pixel;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_index = brl_pkg::REG_FRAME_WIDTH;
    logic [brl_pkg::FRAME_W-1:0]  i_cfg_data = '0;

    // lines waiting to be sent and pixels still owed by the block
    t_pending_line                line_q[$];
    brl_pkg::t_pixel_item         pixel_q[$];

    // local copy of the frame registers
    int                  frame_w = 64;
    int                  frame_h = 64;

    int                  idle_pct = 0;
    int                  err_count = 0;
    int                  lines_sent = 0;
    int                  pixels_checked = 0;
    int                  frame_settings = 1;
    int                  cycle_count = 0;

    bresenham_line_rasterizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_pixel    (o_pixel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // walk one segment with the error-term method and queue every pixel it emits
    function automatic void queue_segment_pixels(input brl_pkg::t_line_item seg);
        int x, y, xe, ye, dx, dy, sx, sy, err, e2, n;
        bit at_end;
        brl_pkg::t_pixel_item px;
        x  = seg.start_x;
        y  = seg.start_y;
        xe = seg.end_x;
        ye = seg.end_y;
        // coordinates past the tile saturate (never hit with a 64-pixel tile)
        if (x > brl_pkg::TILE_SIZE - 1) x = brl_pkg::TILE_SIZE - 1;
        if (y > brl_pkg::TILE_SIZE - 1) y = brl_pkg::TILE_SIZE - 1;
        if (xe > brl_pkg::TILE_SIZE - 1) xe = brl_pkg::TILE_SIZE - 1;
        if (ye > brl_pkg::TILE_SIZE - 1) ye = brl_pkg::TILE_SIZE - 1;
        dx  = (xe > x) ? xe - x : x - xe;
        dy  = (ye > y) ? y - ye : ye - y;
        sx  = (x < xe) ? 1 : -1;
        sy  = (y < ye) ? 1 : -1;
        err = dx + dy;
        n   = 0;
        while (n < brl_pkg::TILE_SIZE) begin
            at_end = (x == xe) && (y == ye);
            px.pixel_x      = brl_pkg::t_coord'(x);
            px.pixel_y      = brl_pkg::t_coord'(y);
            px.pixel_color  = seg.line_color;
            px.inside_frame = (x < frame_w) && (y < frame_h);
            px.last_pixel   = at_end;
            pixel_q.insert(pixel_q.size(), px);
            n++;
            if (at_end) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    // one-line mismatch report
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MAX_PRINTED)
            $display("[%0t] pixel mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what,
                     got, want);
        err_count++;
    endtask

    function automatic brl_pkg::t_line_item mk_line(input int sx, input int sy, input int ex,
                                                    input int ey,
                                                    input logic [brl_pkg::COLOR_W-1:0] c);
        brl_pkg::t_line_item it;
        it.start_x    = brl_pkg::t_coord'(sx);
        it.start_y    = brl_pkg::t_coord'(sy);
        it.end_x      = brl_pkg::t_coord'(ex);
        it.end_y      = brl_pkg::t_coord'(ey);
        it.line_color = c;
        return it;
    endfunction

    // random segment: mostly short or axis/diagonal lines, some fully random
    function automatic brl_pkg::t_line_item random_line();
        int kind, sx, sy, ex, ey, len;
        kind = $urandom_range(9);
        sx = $urandom_range(63);
        sy = $urandom_range(63);
        ex = $urandom_range(63);
        ey = $urandom_range(63);
        case (kind)
            3, 4, 5: begin
                ex = sx + $urandom_range(14) - 7;
                ey = sy + $urandom_range(14) - 7;
                if (ex < 0) ex = 0;
                if (ex > 63) ex = 63;
                if (ey < 0) ey = 0;
                if (ey > 63) ey = 63;
            end
            6: ey = sy;
            7: ex = sx;
            8: begin
                len = $urandom_range(63);
                ex = ($urandom_range(1) != 0) ? sx + len : sx - len;
                ey = ($urandom_range(1) != 0) ? sy + len : sy - len;
                if (ex < 0 || ex > 63) ex = sx;
                if (ey < 0 || ey > 63) ey = sy;
            end
            9: begin
                ex = sx;
                ey = sy;
            end
            default: ;
        endcase
        return mk_line(sx, sy, ex, ey, brl_pkg::COLOR_W'($urandom()));
    endfunction

    task automatic add_line(input brl_pkg::t_line_item it, input bit drain_first);
        t_pending_line p;
        p.line = it;
        p.wait_drain = drain_first;
        line_q.insert(line_q.size(), p);
    endtask

    // write both frame registers back to back; only called while idle
    task automatic set_frame(input int w, input int h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= brl_pkg::REG_FRAME_WIDTH;
        i_cfg_data  <= brl_pkg::FRAME_W'(w);
        @(posedge i_clk);
        i_cfg_index <= brl_pkg::REG_FRAME_HEIGHT;
        i_cfg_data  <= brl_pkg::FRAME_W'(h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_w = w;
        frame_h = h;
        frame_settings++;
    endtask

    // wait for every line to go out and every pixel to come back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (line_q.size() != 0 || start || pixel_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // line driver: holds start until taken, then maybe idles before the next item
    always @(posedge i_clk) begin : line_driver
        t_pending_line nxt;
        bit present;
        present = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                queue_segment_pixels(i_item);
                lines_sent++;
            end
            if (!start || !busy) begin
                if (line_q.size() != 0 && $urandom_range(99) >= idle_pct &&
                    (!line_q[0].wait_drain || pixel_q.size() == 0)) begin
                    nxt = line_q.pop_front();
                    i_item <= nxt.line;
                    present = 1'b1;
                end
                start <= present;
            end
        end
    end

    // pixel monitor: every strobed pixel is checked against the oldest prediction
    always @(posedge i_clk) begin : pixel_monitor
        brl_pkg::t_pixel_item want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected pixel", o_pixel, 0);
            end else begin
                want = pixel_q.pop_front();
                pixels_checked++;
                if (o_pixel.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", o_pixel.pixel_x, want.pixel_x);
                if (o_pixel.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", o_pixel.pixel_y, want.pixel_y);
                if (o_pixel.pixel_color !== want.pixel_color)
                    report_mismatch("pixel_color", o_pixel.pixel_color, want.pixel_color);
                if (o_pixel.inside_frame !== want.inside_frame)
                    report_mismatch("inside_frame", o_pixel.inside_frame, want.inside_frame);
                if (o_pixel.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", o_pixel.last_pixel, want.last_pixel);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int fw[NUM_PHASES];
        int fh[NUM_PHASES];
        fw = '{0, 127, 1, 64, 0, 0, 0, 0};
        fh = '{127, 0, 64, 1, 0, 0, 0, 0};
        for (int p = 4; p < NUM_PHASES; p++) begin
            fw[p] = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
            fh[p] = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines under the reset frame: single points, tile corners, all octants
        idle_pct = 38;
        add_line(mk_line(0, 0, 0, 0, 24'h000000), 1'b0);
        add_line(mk_line(63, 63, 63, 63, 24'hFFFFFF), 1'b0);
        add_line(mk_line(0, 0, 63, 63, 24'hA5A5A5), 1'b0);
        add_line(mk_line(63, 63, 0, 0, 24'h5A5A5A), 1'b0);
        add_line(mk_line(63, 0, 0, 63, 24'hFF0000), 1'b0);
        add_line(mk_line(0, 63, 63, 0, 24'h00FF00), 1'b1);
        add_line(mk_line(0, 0, 63, 0, 24'h0000FF), 1'b0);
        add_line(mk_line(63, 5, 0, 5, 24'h123456), 1'b0);
        add_line(mk_line(7, 0, 7, 63, 24'h654321), 1'b0);
        add_line(mk_line(9, 63, 9, 0, 24'hFFFFFF), 1'b0);
        add_line(mk_line(32, 32, 40, 35, 24'h800001), 1'b0);
        add_line(mk_line(32, 32, 35, 40, 24'h010080), 1'b0);
        add_line(mk_line(32, 32, 29, 40, 24'h7F7F7F), 1'b0);
        add_line(mk_line(32, 32, 24, 35, 24'h808080), 1'b0);
        add_line(mk_line(32, 32, 24, 29, 24'hC0FFEE), 1'b0);
        add_line(mk_line(32, 32, 29, 24, 24'h0F0F0F), 1'b0);
        add_line(mk_line(32, 32, 35, 24, 24'hF0F0F0), 1'b0);
        add_line(mk_line(32, 32, 40, 29, 24'h3C3C3C), 1'b0);
        add_line(mk_line(0, 0, 63, 1, 24'hC3C3C3), 1'b0);
        add_line(mk_line(1, 0, 0, 63, 24'h000001), 1'b0);
        add_line(mk_line(62, 1, 63, 0, 24'h800000), 1'b0);
        wait_drained();

        // random lines under a series of frame sizes, extremes first
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_frame(fw[p], fh[p]);
            idle_pct = (p < 3) ? 38 : (p < 6) ? 47 : 0;
            for (int i = 0; i < PHASE_LINES; i++)
                add_line(random_line(), $urandom_range(24) == 0);
            wait_drained();
        end

        $display("covered %0d lines and %0d pixels over %0d frame sizes, idle gaps 38/47/0 pct",
                 lines_sent, pixels_checked, frame_settings);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/brl_pkg.sv
hw/rtl/brl_ctrl.sv
hw/rtl/brl_datapath.sv
hw/rtl/bresenham_line_rasterizer.sv
sim/bresenham_line_rasterizer_tb.sv
